// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMP(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed: label");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed: label");

// Next-cycle implication that also holds through reset.
`define ASSERT_NXT_ALWAYS(label, clk, lhs, rhs) \
   label: assert property (@(posedge clk) (lhs) |=> (rhs)) \
      else $error("assertion failed: label");

`endif

// ===== hw/rtl/fpwm_pkg.sv =====
// ----------------------------------------------------------------------------
// fpwm_pkg
// Types and constants of the three-channel fading PWM driver.
// ----------------------------------------------------------------------------
`default_nettype none

package fpwm_pkg;

   localparam int LEVEL_W = 7;
   localparam int DIV_W   = 4;
   localparam int CSR_IDX_W = 2;

   localparam logic [LEVEL_W-1:0] BREATH_START = 7'd50;

   localparam logic [DIV_W-1:0] BASE_DIV_RESET   = 4'd1;
   localparam logic [DIV_W-1:0] ARC_DIV_RESET    = 4'd2;
   localparam logic [DIV_W-1:0] BREATH_DIV_RESET = 4'd4;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASE_DIV   = 2'd0,
      CSR_ARC_DIV    = 2'd1,
      CSR_BREATH_DIV = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] base;
      logic [LEVEL_W-1:0] arc;
      logic [LEVEL_W-1:0] breath;
   } levels_type;

   typedef struct packed {
      logic base_pin;
      logic base_inv_pin;
      logic arc_pin;
      logic arc_inv_pin;
      logic breath_pin;
   } pins_type;

endpackage

`default_nettype wire

// ===== hw/rtl/fpwm_if.sv =====
// ----------------------------------------------------------------------------
// fpwm_req_if / fpwm_rsp_if
// Valid/ready channels for tick beats and pin beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface fpwm_req_if;
   logic valid;
   logic ready;
   logic pwm_tick;
   logic fade_tick;

   modport source (output valid, output pwm_tick, output fade_tick, input ready);
   modport sink   (input valid, input pwm_tick, input fade_tick, output ready);
endinterface

interface fpwm_rsp_if;
   logic valid;
   logic ready;
   logic base_pin;
   logic base_inv_pin;
   logic arc_pin;
   logic arc_inv_pin;
   logic breath_pin;

   modport source (output valid, output base_pin, output base_inv_pin, output arc_pin,
                   output arc_inv_pin, output breath_pin, input ready);
   modport sink   (input valid, input base_pin, input base_inv_pin, input arc_pin,
                   input arc_inv_pin, input breath_pin, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/fpwm_ramp.sv =====
// ----------------------------------------------------------------------------
// fpwm_ramp
// One fade channel: divider counter and triangle ramp between 0 and STEPS.
// ----------------------------------------------------------------------------
`default_nettype none

module fpwm_ramp #(
   parameter int STEPS        = 100,
   parameter int RESET_LEVEL  = 0,
   parameter bit RESET_RISING = 1'b1
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              step_en,
   input  wire logic [fpwm_pkg::DIV_W-1:0]        divider,
   output logic      [fpwm_pkg::LEVEL_W-1:0]      level
);

   localparam int LW = fpwm_pkg::LEVEL_W;
   localparam int DW = fpwm_pkg::DIV_W;
   localparam logic [LW-1:0] STEPS_L = LW'(STEPS);

   logic [LW-1:0] level_ff, level_in;
   logic          rising_ff, rising_in;
   logic [DW-1:0] count_ff, count_in;
   logic [DW:0]   count_next;
   logic          fire;
   logic          turn_rise;

   always_comb begin
      count_next = {1'b0, count_ff} + {{DW{1'b0}}, 1'b1};
      fire       = count_next >= {1'b0, divider};
      level_in   = level_ff;
      rising_in  = rising_ff;
      count_in   = count_ff;
      turn_rise  = 1'b0;
      if (step_en) begin
         if (fire) begin
            count_in = '0;
            // The direction flips at either end before the level moves.
            if (rising_ff && (level_ff >= STEPS_L)) begin
               rising_in = 1'b0;
            end else if (!rising_ff && (level_ff == '0)) begin
               rising_in = 1'b1;
               turn_rise = 1'b1;
            end
            if (rising_in || turn_rise) begin
               level_in = level_ff + {{(LW-1){1'b0}}, 1'b1};
            end else begin
               level_in = level_ff - {{(LW-1){1'b0}}, 1'b1};
            end
         end else begin
            count_in = count_next[DW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff  <= LW'(RESET_LEVEL);
         rising_ff <= RESET_RISING;
         count_ff  <= '0;
      end else begin
         level_ff  <= level_in;
         rising_ff <= rising_in;
         count_ff  <= count_in;
      end
   end

   assign level = level_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/fpwm_pwm.sv =====
// ----------------------------------------------------------------------------
// fpwm_pwm
// Shared phase counter and the five pin comparators with their pin register.
// ----------------------------------------------------------------------------
`default_nettype none

module fpwm_pwm #(
   parameter int STEPS = 100
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 tick_en,
   input  wire fpwm_pkg::levels_type levels,
   output fpwm_pkg::pins_type        pins
);

   localparam int LW = fpwm_pkg::LEVEL_W;
   localparam logic [LW-1:0] STEPS_L = LW'(STEPS);

   logic [LW-1:0]      phase_ff, phase_in;
   logic [LW-1:0]      phase_inc;
   logic [LW-1:0]      base_comp, arc_comp;
   fpwm_pkg::pins_type pins_ff, pins_in;

   always_comb begin
      // A level above full scale leaves no room for the inverted pin.
      base_comp = (levels.base <= STEPS_L) ? (STEPS_L - levels.base) : '0;
      arc_comp  = (levels.arc  <= STEPS_L) ? (STEPS_L - levels.arc)  : '0;
      phase_inc = phase_ff + {{(LW-1){1'b0}}, 1'b1};
      phase_in  = phase_ff;
      pins_in   = pins_ff;
      if (tick_en) begin
         pins_in.base_pin     = phase_ff < levels.base;
         pins_in.base_inv_pin = phase_ff < base_comp;
         pins_in.arc_pin      = phase_ff < levels.arc;
         pins_in.arc_inv_pin  = phase_ff < arc_comp;
         pins_in.breath_pin   = phase_ff < levels.breath;
         phase_in = (phase_inc >= STEPS_L) ? '0 : phase_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         pins_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         pins_ff  <= pins_in;
      end
   end

   assign pins = pins_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/three_channel_fading_pwm.sv =====
// ----------------------------------------------------------------------------
// three_channel_fading_pwm
// Software-style PWM driver for five LED pins with three triangle fades.
// ----------------------------------------------------------------------------
// Each req beat carries a PWM tick flag and a fade tick flag. A PWM tick
// samples the phase against the current brightness levels into the pin
// register and then advances the phase, which wraps at STEPS. A fade tick
// advances each channel divider; a divider that fires steps its level one
// count along a triangle between 0 and STEPS.
// Every req beat yields exactly one rsp beat holding the five pin levels;
// without a PWM tick the pins repeat their previous values.
// The rsp beat appears in the cycle after the req beat is accepted.
// Throughput is one beat per cycle, set by the single result register; req
// is taken while that register is empty or being drained in the same cycle.
// When the receiver stalls, the rsp beat holds and req_if.ready falls.
// Reset is synchronous: levels, directions, dividers and the phase return to
// their start values and no rsp beat is pending. The csr port writes the
// divider registers at any edge with csr_we high; indexes past the last
// register are ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module three_channel_fading_pwm #(
   parameter int STEPS = 100
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   fpwm_req_if.sink                                 req_if,
   fpwm_rsp_if.source                               rsp_if,
   input  wire logic                                csr_we,
   input  wire logic [fpwm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [fpwm_pkg::DIV_W-1:0]          csr_data
);

   localparam int DW = fpwm_pkg::DIV_W;

   logic [DW-1:0] base_div_ff, base_div_in;
   logic [DW-1:0] arc_div_ff, arc_div_in;
   logic [DW-1:0] breath_div_ff, breath_div_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          accept;

   fpwm_pkg::levels_type levels;
   fpwm_pkg::pins_type   pins;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;

   always_comb begin
      base_div_in   = base_div_ff;
      arc_div_in    = arc_div_ff;
      breath_div_in = breath_div_ff;
      if (csr_we) begin
         case (fpwm_pkg::csr_index_type'(csr_index))
            fpwm_pkg::CSR_BASE_DIV:   base_div_in   = csr_data;
            fpwm_pkg::CSR_ARC_DIV:    arc_div_in    = csr_data;
            fpwm_pkg::CSR_BREATH_DIV: breath_div_in = csr_data;
            default: ;
         endcase
      end
      rsp_valid_in = accept || (rsp_valid_ff && !rsp_if.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_div_ff   <= fpwm_pkg::BASE_DIV_RESET;
         arc_div_ff    <= fpwm_pkg::ARC_DIV_RESET;
         breath_div_ff <= fpwm_pkg::BREATH_DIV_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         base_div_ff   <= base_div_in;
         arc_div_ff    <= arc_div_in;
         breath_div_ff <= breath_div_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   fpwm_ramp #(.STEPS(STEPS), .RESET_LEVEL(0), .RESET_RISING(1'b1)) u_base_ramp (
      .clock   (clock),
      .reset   (reset),
      .step_en (accept && req_if.fade_tick),
      .divider (base_div_ff),
      .level   (levels.base)
   );

   fpwm_ramp #(.STEPS(STEPS), .RESET_LEVEL(STEPS), .RESET_RISING(1'b0)) u_arc_ramp (
      .clock   (clock),
      .reset   (reset),
      .step_en (accept && req_if.fade_tick),
      .divider (arc_div_ff),
      .level   (levels.arc)
   );

   fpwm_ramp #(
      .STEPS        (STEPS),
      .RESET_LEVEL  (int'(fpwm_pkg::BREATH_START)),
      .RESET_RISING (1'b1)
   ) u_breath_ramp (
      .clock   (clock),
      .reset   (reset),
      .step_en (accept && req_if.fade_tick),
      .divider (breath_div_ff),
      .level   (levels.breath)
   );

   // The pin register doubles as the rsp payload; it only changes on a
   // beat that is accepted, which requires the previous rsp beat to leave.
   fpwm_pwm #(.STEPS(STEPS)) u_pwm (
      .clock   (clock),
      .reset   (reset),
      .tick_en (accept && req_if.pwm_tick),
      .levels  (levels),
      .pins    (pins)
   );

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.base_pin     = pins.base_pin;
   assign rsp_if.base_inv_pin = pins.base_inv_pin;
   assign rsp_if.arc_pin      = pins.arc_pin;
   assign rsp_if.arc_inv_pin  = pins.arc_inv_pin;
   assign rsp_if.breath_pin   = pins.breath_pin;

endmodule

`default_nettype wire

// ===== hw/rtl/fpwm_checker.sv =====
// ----------------------------------------------------------------------------
// fpwm_checker
// Port-level checks of the fading PWM driver, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fpwm_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic base_pin,
   input wire logic base_inv_pin,
   input wire logic arc_pin,
   input wire logic arc_inv_pin,
   input wire logic breath_pin
);

   logic [4:0] pin_bus;

   assign pin_bus = {base_pin, base_inv_pin, arc_pin, arc_inv_pin, breath_pin};

   // Nothing is pending right after reset.
   `ASSERT_NXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)

   // An accepted req beat always produces an rsp beat in the next cycle.
   `ASSERT_NXT(a_req_to_rsp, clock, reset, req_valid && req_ready, rsp_valid)

   // With the result register empty, a new beat is always taken.
   `ASSERT_IMP(a_ready_when_empty, clock, reset, !rsp_valid, req_ready)

   // A stalled rsp beat stays valid and keeps its payload.
   `ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(pin_bus))

endmodule

bind three_channel_fading_pwm fpwm_checker u_fpwm_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_if.valid),
   .req_ready    (req_if.ready),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .base_pin     (rsp_if.base_pin),
   .base_inv_pin (rsp_if.base_inv_pin),
   .arc_pin      (rsp_if.arc_pin),
   .arc_inv_pin  (rsp_if.arc_inv_pin),
   .breath_pin   (rsp_if.breath_pin)
);

`default_nettype wire

// ===== test/tb_three_channel_fading_pwm.sv =====
// ----------------------------------------------------------------------------
// tb_three_channel_fading_pwm
// Self-checking bench for the three-channel fading PWM driver.
// ----------------------------------------------------------------------------
// A short table of tick beats and divider writes runs first. Random tick
// beats follow, in phases with different divider settings. A local copy of
// the phase counter, ramps and dividers predicts each untyped rsp beat.
// The sender idles in bursts and the receiver stalls on a rotating pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_three_channel_fading_pwm;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STEPS       = 100;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_BEATS = 110;

   // Index past the last divider register; writes to it must be dropped.
   localparam logic [fpwm_pkg::CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef enum logic {ROW_BEAT, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type                     kind;
      logic [fpwm_pkg::CSR_IDX_W-1:0]   index;
      logic [fpwm_pkg::DIV_W-1:0]       data;
      logic                             pwm;
      logic                             fade;
      logic                             typed;
      fpwm_pkg::pins_type               pins;
   } plan_row_type;

   localparam plan_row_type PLAN [24] = '{
      '{ROW_BEAT, fpwm_pkg::CSR_BASE_DIV,   4'd0,  1'b0, 1'b0, 1'b1, 5'b00000},
      '{ROW_BEAT, fpwm_pkg::CSR_BASE_DIV,   4'd0,  1'b1, 1'b0, 1'b1, 5'b01101},
      '{ROW_BEAT, fpwm_pkg::CSR_BASE_DIV,   4'd0,  1'b1, 1'b1, 1'b0, 5'b00000},
      '{ROW_BEAT, fpwm_pkg::CSR_BASE_DIV,   4'd0,  1'b0, 1'b1, 1'b0, 5'b00000},
      '{ROW_BEAT, fpwm_pkg::CSR_BASE_DIV,   4'd0,  1'b0, 1'b0, 1'b0, 5'b00000},
      '{ROW_BEAT, fpwm_pkg::CSR_BASE_DIV,   4'd0,  1'b1, 1'b1, 1'b0, 5'b00000},
      '{ROW_CSR,  fpwm_pkg::CSR_BASE_DIV,   4'd15, 1'b0, 1'b0, 1'b0, 5'b00000},
      '{ROW_CSR,  fpwm_pkg::CSR_ARC_DIV,    4'd15, 1'b0, 1'b0, 1'b0, 5'b00000},
      '{ROW_CSR,  fpwm_pkg::CSR_BREATH_DIV, 4'd15, 1'b0, 1'b0, 1'b0, 5'b00000},
      '{ROW_BEAT, fpwm_pkg::CSR_BASE_DIV,   4'd0,  1'b0, 1'b1, 1'b0, 5'b00000},
      '{ROW_BEAT, fpwm_pkg::CSR_BASE_DIV,   4'd0,  1'b1, 1'b1, 1'b0, 5'b00000},
      '{ROW_BEAT, fpwm_pkg::CSR_BASE_DIV,   4'd0,  1'b0, 1'b1, 1'b0, 5'b00000},
      '{ROW_BEAT, fpwm_pkg::CSR_BASE_DIV,   4'd0,  1'b1, 1'b1, 1'b0, 5'b00000},
      '{ROW_BEAT, fpwm_pkg::CSR_BASE_DIV,   4'd0,  1'b0, 1'b1, 1'b0, 5'b00000},
      '{ROW_BEAT, fpwm_pkg::CSR_BASE_DIV,   4'd0,  1'b0, 1'b1, 1'b0, 5'b00000},
      '{ROW_CSR,  fpwm_pkg::CSR_BASE_DIV,   4'd2,  1'b0, 1'b0, 1'b0, 5'b00000},
      '{ROW_CSR,  fpwm_pkg::CSR_ARC_DIV,    4'd0,  1'b0, 1'b0, 1'b0, 5'b00000},
      '{ROW_CSR,  fpwm_pkg::CSR_BREATH_DIV, 4'd3,  1'b0, 1'b0, 1'b0, 5'b00000},
      '{ROW_BEAT, fpwm_pkg::CSR_BASE_DIV,   4'd0,  1'b1, 1'b1, 1'b0, 5'b00000},
      '{ROW_BEAT, fpwm_pkg::CSR_BASE_DIV,   4'd0,  1'b0, 1'b1, 1'b0, 5'b00000},
      '{ROW_BEAT, fpwm_pkg::CSR_BASE_DIV,   4'd0,  1'b1, 1'b0, 1'b0, 5'b00000},
      '{ROW_CSR,  CSR_SPARE,                4'd9,  1'b0, 1'b0, 1'b0, 5'b00000},
      '{ROW_BEAT, fpwm_pkg::CSR_BASE_DIV,   4'd0,  1'b1, 1'b1, 1'b0, 5'b00000},
      '{ROW_BEAT, fpwm_pkg::CSR_BASE_DIV,   4'd0,  1'b0, 1'b0, 1'b0, 5'b00000}
   };

   logic clock = 1'b0;
   logic reset;
   logic                           csr_we;
   logic [fpwm_pkg::CSR_IDX_W-1:0] csr_index;
   logic [fpwm_pkg::DIV_W-1:0]     csr_data;

   fpwm_req_if req_if ();
   fpwm_rsp_if rsp_if ();

   three_channel_fading_pwm #(
      .STEPS(STEPS)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if.sink),
      .rsp_if    (rsp_if.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #2 clock = ~clock;

   // Local copy of the driver state, indexed by channel (same order as the
   // divider registers).
   logic [fpwm_pkg::LEVEL_W-1:0] phase_q;
   logic [fpwm_pkg::LEVEL_W-1:0] level_q   [3];
   logic                         rising_q  [3];
   logic [fpwm_pkg::DIV_W-1:0]   count_q   [3];
   logic [fpwm_pkg::DIV_W-1:0]   divider_q [3];
   fpwm_pkg::pins_type           pins_q;

   fpwm_pkg::pins_type pending_pins [$];
   int                 fail_count = 0;
   int                 burst_left = 0;

   task automatic reset_pin_model();
      phase_q                             = '0;
      level_q[fpwm_pkg::CSR_BASE_DIV]     = '0;
      level_q[fpwm_pkg::CSR_ARC_DIV]      = fpwm_pkg::LEVEL_W'(STEPS);
      level_q[fpwm_pkg::CSR_BREATH_DIV]   = fpwm_pkg::BREATH_START;
      rising_q[fpwm_pkg::CSR_BASE_DIV]    = 1'b1;
      rising_q[fpwm_pkg::CSR_ARC_DIV]     = 1'b0;
      rising_q[fpwm_pkg::CSR_BREATH_DIV]  = 1'b1;
      divider_q[fpwm_pkg::CSR_BASE_DIV]   = fpwm_pkg::BASE_DIV_RESET;
      divider_q[fpwm_pkg::CSR_ARC_DIV]    = fpwm_pkg::ARC_DIV_RESET;
      divider_q[fpwm_pkg::CSR_BREATH_DIV] = fpwm_pkg::BREATH_DIV_RESET;
      for (int ch = 0; ch < 3; ch++) count_q[ch] = '0;
      pins_q = '0;
   endtask

   function automatic int mirror_level(int lvl);
      return (lvl <= STEPS) ? STEPS - lvl : 0;
   endfunction

   // Applies one tick beat to the local state and returns the pins it shows.
   task automatic predict_pins(input logic pwm, input logic fade,
                               output fpwm_pkg::pins_type pins);
      int p;
      logic [fpwm_pkg::DIV_W:0] next;
      if (pwm) begin
         p = phase_q;
         pins_q.base_pin     = p < int'(level_q[fpwm_pkg::CSR_BASE_DIV]);
         pins_q.base_inv_pin = p < mirror_level(level_q[fpwm_pkg::CSR_BASE_DIV]);
         pins_q.arc_pin      = p < int'(level_q[fpwm_pkg::CSR_ARC_DIV]);
         pins_q.arc_inv_pin  = p < mirror_level(level_q[fpwm_pkg::CSR_ARC_DIV]);
         pins_q.breath_pin   = p < int'(level_q[fpwm_pkg::CSR_BREATH_DIV]);
         p++;
         if (p >= STEPS) p = 0;
         phase_q = p[fpwm_pkg::LEVEL_W-1:0];
      end
      if (fade) begin
         for (int ch = 0; ch < 3; ch++) begin
            next = {1'b0, count_q[ch]} + 1'b1;
            if (next >= {1'b0, divider_q[ch]}) begin
               count_q[ch] = '0;
               // The ramp turns around at either end before taking its step.
               if (rising_q[ch] && int'(level_q[ch]) >= STEPS) rising_q[ch] = 1'b0;
               else if (!rising_q[ch] && level_q[ch] == '0) rising_q[ch] = 1'b1;
               if (rising_q[ch]) level_q[ch] = level_q[ch] + 1'b1;
               else level_q[ch] = level_q[ch] - 1'b1;
            end else begin
               count_q[ch] = next[fpwm_pkg::DIV_W-1:0];
            end
         end
      end
      pins = pins_q;
   endtask

   task automatic send_tick(input logic pwm, input logic fade,
                            input logic typed, input fpwm_pkg::pins_type typed_pins);
      int gap;
      fpwm_pkg::pins_type predicted;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_if.valid     <= 1'b1;
      req_if.pwm_tick  <= pwm;
      req_if.fade_tick <= fade;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      predict_pins(pwm, fade, predicted);
      pending_pins.push_back(typed ? typed_pins : predicted);
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (pending_pins.size() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic write_divider(input logic [fpwm_pkg::CSR_IDX_W-1:0] idx,
                                input logic [fpwm_pkg::DIV_W-1:0] val);
      wait_drained();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      if (idx != CSR_SPARE) divider_q[idx] = val;
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic void check_pin(string name, logic want, logic got);
      if (got !== want) begin
         $error("%s: expected %0b, got %0b", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      fpwm_pkg::pins_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_pins.size() == 0) begin
            $error("pin beat arrived with nothing expected");
            fail_count++;
         end else begin
            want = pending_pins.pop_front();
            check_pin("base_pin",     want.base_pin,     rsp_if.base_pin);
            check_pin("base_inv_pin", want.base_inv_pin, rsp_if.base_inv_pin);
            check_pin("arc_pin",      want.arc_pin,      rsp_if.arc_pin);
            check_pin("arc_inv_pin",  want.arc_inv_pin,  rsp_if.arc_inv_pin);
            check_pin("breath_pin",   want.breath_pin,   rsp_if.breath_pin);
         end
      end
   end

   // Receiver back-pressure rotates through always ready, light stalls,
   // heavy stalls and a fixed one-in-three pattern.
   initial begin
      int cyc;
      cyc = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         cyc++;
         case ((cyc / 64) % 4)
            0:       rsp_if.ready <= 1'b1;
            1:       rsp_if.ready <= ($urandom_range(0, 3) != 0);
            2:       rsp_if.ready <= ($urandom_range(0, 3) == 0);
            default: rsp_if.ready <= ((cyc % 3) == 0);
         endcase
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("FAIL three_channel_fading_pwm");
      $finish;
   end

   initial begin
      logic [fpwm_pkg::DIV_W-1:0] divs [3];
      int pwm_pct;
      int fade_pct;
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.pwm_tick  = 1'b0;
      req_if.fade_tick = 1'b0;
      csr_we           = 1'b0;
      csr_index        = '0;
      csr_data         = '0;
      reset_pin_model();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (PLAN[i]) begin
         if (PLAN[i].kind == ROW_CSR) write_divider(PLAN[i].index, PLAN[i].data);
         else send_tick(PLAN[i].pwm, PLAN[i].fade, PLAN[i].typed, PLAN[i].pins);
      end

      // Fast-fade phases push the ramps through both turning points.
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0:       divs = '{4'd1, 4'd1, 4'd1};
            1:       divs = '{4'd15, 4'd15, 4'd15};
            2:       divs = '{4'd0, 4'd0, 4'd0};
            3:       divs = '{4'($urandom_range(1, 15)), 4'($urandom_range(1, 15)),
                              4'($urandom_range(1, 15))};
            default: divs = '{fpwm_pkg::BASE_DIV_RESET, fpwm_pkg::ARC_DIV_RESET,
                              fpwm_pkg::BREATH_DIV_RESET};
         endcase
         write_divider(fpwm_pkg::CSR_BASE_DIV, divs[0]);
         write_divider(fpwm_pkg::CSR_ARC_DIV, divs[1]);
         write_divider(fpwm_pkg::CSR_BREATH_DIV, divs[2]);
         if (ph == 3) write_divider(CSR_SPARE, 4'($urandom));
         pwm_pct  = (ph == 1) ? 90 : 65;
         fade_pct = (ph == 0 || ph == 2) ? 90 : 50;
         repeat (PHASE_BEATS)
            send_tick($urandom_range(0, 99) < pwm_pct, $urandom_range(0, 99) < fade_pct,
                      1'b0, '0);
      end

      wait_drained();
      repeat (4) @(posedge clock);
      if (fail_count == 0) $display("PASS three_channel_fading_pwm");
      else $display("FAIL three_channel_fading_pwm");
      $finish;
   end

endmodule

`default_nettype wire
